>>> rtl/sitoa_pkg.sv
// ----------------------------------------------------------------------------
// sitoa_pkg
// Shared types, constants and helpers for the signed integer to decimal
// ASCII converter.
// ----------------------------------------------------------------------------
package sitoa_pkg;

    // Default input width.
    localparam int VALUE_BITS_DEFAULT = 32;

    // ASCII codes for the output text.
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;

    // Double-dabble correction: digits at or above the threshold get the bias.
    localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0] BCD_ADJ_ADD = 4'd3;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_EMIT
    } state_t;

    // Control shared by every digit cell.
    typedef struct packed {
        logic clear;   // zero the digit
        logic conv;    // double-dabble step: adjust, shift in one bit
        logic shift;   // move digits one place toward the top cell
    } cell_ctrl_t;

    // Decimal digits needed for the largest magnitude, 2^(bits-1).
    // Evaluated at elaboration only.
    function automatic int num_digits(input int bits);
        longint unsigned v;
        int              n;
        v = longint'(1) << (bits - 1);
        n = 0;
        while (v != 0) begin
            v = v / 10;
            n = n + 1;
        end
        return n;
    endfunction

endpackage

>>> rtl/sitoa_cell.sv
// ----------------------------------------------------------------------------
// sitoa_cell
// One BCD digit of the conversion chain: double-dabble step, or shift of
// the neighbor's digit for emission.
// ----------------------------------------------------------------------------
module sitoa_cell (
    input  logic                  aclk,
    input  sitoa_pkg::cell_ctrl_t ctrl,
    input  logic                  bit_in,     // carry from the lower cell
    input  logic [3:0]            digit_in,   // digit of the lower cell
    output logic                  carry_out,  // carry to the upper cell
    output logic [3:0]            digit_out
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    // Bias digits of five and up so the shift carries correctly
    assign adj       = (digit_reg >= sitoa_pkg::BCD_ADJ_MIN) ?
                       (digit_reg + sitoa_pkg::BCD_ADJ_ADD) : digit_reg;
    assign carry_out = adj[3];
    assign digit_out = digit_reg;

    // Select the next digit
    always_comb begin
        digit_next = digit_reg;
        if (ctrl.clear) begin
            digit_next = 4'd0;
        end else if (ctrl.conv) begin
            digit_next = {adj[2:0], bit_in};
        end else if (ctrl.shift) begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
    end

endmodule

>>> rtl/sitoa_chain.sv
// ----------------------------------------------------------------------------
// sitoa_chain
// Row of BCD digit cells, least significant digit in cell 0; the top cell
// presents the digit that is emitted next.
// ----------------------------------------------------------------------------
module sitoa_chain #(
    parameter int NUM_DIGITS = 10
) (
    input  logic                  aclk,
    input  sitoa_pkg::cell_ctrl_t ctrl,
    input  logic                  bit_in,     // next magnitude bit, MSB first
    output logic [3:0]            top_digit
);

    logic       carry [NUM_DIGITS-1];
    logic [3:0] digit [NUM_DIGITS];

    // Link each cell to its lower neighbor
    for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
        if (i == 0) begin : g_first
            sitoa_cell u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl),
                .bit_in    (bit_in),
                .digit_in  (4'd0),
                .carry_out (carry[i]),
                .digit_out (digit[i])
            );
        end else if (i == NUM_DIGITS - 1) begin : g_last
            sitoa_cell u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl),
                .bit_in    (carry[i-1]),
                .digit_in  (digit[i-1]),
                .carry_out (),
                .digit_out (digit[i])
            );
        end else begin : g_mid
            sitoa_cell u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl),
                .bit_in    (carry[i-1]),
                .digit_in  (digit[i-1]),
                .carry_out (carry[i]),
                .digit_out (digit[i])
            );
        end
    end

    assign top_digit = digit[NUM_DIGITS-1];

endmodule

>>> rtl/signed_int_to_decimal_ascii.sv
// Sequence: accept the word, shift its magnitude through the digit chain
// one bit per cycle, emit a minus sign for a negative word, then sweep
// out all NUM_DIGITS digits. Leading zeros are swept but not emitted, so
// the sweep covers every digit whatever the value; the sign and each digit
// of the sweep wait while the output register is full and m_tready is low.
// The next word is taken while the last character still waits in the
// output register. aresetn (synchronous, active low) clears all control.
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed two's-complement word to decimal ASCII text, most
// significant character first, last character flagged with m_tlast.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
    parameter int VALUE_BITS = sitoa_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((VALUE_BITS + 7) / 8)*8-1:0] s_tdata,   // [VALUE_BITS-1:0] value
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // [7:0] character
    output logic                                m_tlast    // last_char
);

    localparam int NumDigits = sitoa_pkg::num_digits(VALUE_BITS);
    localparam int CntW      = $clog2(VALUE_BITS + 1);
    localparam int RemW      = $clog2(NumDigits + 1);

    sitoa_pkg::state_t     state_reg, state_next;
    sitoa_pkg::cell_ctrl_t ctrl;

    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic                  neg_reg, neg_next;
    logic [CntW-1:0]       cnt_reg, cnt_next;
    logic [RemW-1:0]       rem_reg, rem_next;
    logic                  started_reg, started_next;
    logic                  m_valid_reg;
    logic [7:0]            m_char_reg;
    logic                  m_last_reg;

    logic [VALUE_BITS-1:0] value;
    logic [VALUE_BITS-1:0] value_mag;
    logic [3:0]            top_digit;
    logic                  out_free;
    logic                  load_out;
    logic [7:0]            out_char;
    logic                  out_last;

    // Magnitude of the incoming word; the most negative value fits unsigned
    assign value     = s_tdata[VALUE_BITS-1:0];
    assign value_mag = value[VALUE_BITS-1] ?
                       ((~value) + {{(VALUE_BITS - 1){1'b0}}, 1'b1}) : value;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == sitoa_pkg::ST_IDLE);

    sitoa_chain #(
        .NUM_DIGITS (NumDigits)
    ) u_chain (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .bit_in    (mag_reg[VALUE_BITS-1]),
        .top_digit (top_digit)
    );

    // Sequence: convert, optional sign, then sweep the digits out
    always_comb begin
        state_next   = state_reg;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        started_next = started_reg;
        ctrl         = '0;
        load_out     = 1'b0;
        out_char     = sitoa_pkg::ASCII_ZERO;
        out_last     = 1'b0;
        case (state_reg)
            sitoa_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    ctrl.clear = 1'b1;
                    mag_next   = value_mag;
                    neg_next   = value[VALUE_BITS-1];
                    cnt_next   = CntW'(VALUE_BITS);
                    state_next = sitoa_pkg::ST_CONV;
                end
            end
            sitoa_pkg::ST_CONV: begin
                ctrl.conv = 1'b1;
                mag_next  = mag_reg << 1;
                cnt_next  = cnt_reg - CntW'(1);
                if (cnt_reg == CntW'(1)) begin
                    rem_next     = RemW'(NumDigits);
                    started_next = 1'b0;
                    state_next   = neg_reg ? sitoa_pkg::ST_SIGN : sitoa_pkg::ST_EMIT;
                end
            end
            sitoa_pkg::ST_SIGN: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    out_char   = sitoa_pkg::ASCII_MINUS;
                    state_next = sitoa_pkg::ST_EMIT;
                end
            end
            sitoa_pkg::ST_EMIT: begin
                if (out_free) begin
                    ctrl.shift = 1'b1;
                    rem_next   = rem_reg - RemW'(1);
                    // Drop leading zeros, but always keep the units digit
                    if (started_reg || (top_digit != 4'd0) || (rem_reg == RemW'(1))) begin
                        load_out     = 1'b1;
                        out_char     = sitoa_pkg::ASCII_ZERO | {4'd0, top_digit};
                        out_last     = (rem_reg == RemW'(1));
                        started_next = 1'b1;
                    end
                    if (rem_reg == RemW'(1)) begin
                        state_next = sitoa_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = sitoa_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sitoa_pkg::ST_IDLE;
            started_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            started_reg <= started_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        if (load_out) begin
            m_char_reg <= out_char;
            m_last_reg <= out_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_char_reg;
    assign m_tlast  = m_last_reg;

    // An accepted word always starts a conversion
    a_accept_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == sitoa_pkg::ST_CONV))
        else $error("accepted word did not start conversion");

    // The emit sweep never runs with no digits left
    a_emit_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sitoa_pkg::ST_EMIT) |-> (rem_reg != '0))
        else $error("emit phase with empty digit count");

    // The flagged last character ends the word
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && out_last) |=> (state_reg == sitoa_pkg::ST_IDLE))
        else $error("last character loaded but sequencer not idle");

    // Output register is never overwritten while a character waits
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> (!m_valid_reg || m_tready))
        else $error("output character overwritten");

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives signed 32-bit words into the decimal ASCII converter and checks the
// emitted text character by character, against a predictor that forms the
// magnitude one bit wider and peels decimal digits off it. In most tests the
// sender idles between bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module testbench;

    localparam int VALUE_BITS = 32;

    typedef struct {
        logic [7:0] character;
        logic       last_char;
    } text_char_t;

    typedef enum int {
        RX_STEADY,
        RX_BURSTY,
        RX_SPARSE
    } rx_mode_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [VALUE_BITS-1:0] s_tdata  = '0;   // [31:0] value
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;         // [7:0] character
    logic                  m_tlast;         // last_char

    text_char_t pending_text[$];
    text_char_t oldest_char;
    int         error_count   = 0;
    rx_mode_t   rx_mode       = RX_STEADY;
    bit         rx_level      = 1'b1;
    int         rx_stretch    = 0;
    bit         tx_gaps_on    = 1'b1;
    int         tx_burst_left = 0;

    signed_int_to_decimal_ascii #(
        .VALUE_BITS(VALUE_BITS)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    // Clock, period 10
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Append the expected text of one word: sign, then digits, top first
    function automatic void predict_text(input logic [VALUE_BITS-1:0] value);
        logic [VALUE_BITS:0] magnitude;
        logic [7:0]          digits[$];
        text_char_t          ch;
        bit                  negative;
        negative  = value[VALUE_BITS-1];
        magnitude = negative ? ({(VALUE_BITS+1){1'b0}} - {value[VALUE_BITS-1], value})
                             : {1'b0, value};
        do begin
            digits.push_front(sitoa_pkg::ASCII_ZERO + 8'(magnitude % 10));
            magnitude = magnitude / 10;
        end while (magnitude != 0);
        if (negative) begin
            ch.character = sitoa_pkg::ASCII_MINUS;
            ch.last_char = 1'b0;
            pending_text.push_back(ch);
        end
        for (int i = 0; i < digits.size(); i++) begin
            ch.character = digits[i];
            ch.last_char = (i == digits.size() - 1);
            pending_text.push_back(ch);
        end
    endfunction

    // Send one word; idle between bursts when gaps are enabled
    task automatic send_value(input logic [VALUE_BITS-1:0] value);
        int gap;
        if (tx_burst_left == 0) begin
            tx_burst_left = $urandom_range(1, 6);
            gap = tx_gaps_on ? $urandom_range(0, 50) : 0;
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        tx_burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        predict_text(value);
    endtask

    // Random word of 1..10 decimal digits with a random sign
    function automatic logic [VALUE_BITS-1:0] random_sized_value();
        longint unsigned limit;
        longint          v;
        int              n;
        n     = $urandom_range(1, 10);
        limit = 1;
        repeat (n) limit = limit * 10;
        v = longint'({$urandom(), $urandom()} % limit);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if ($urandom_range(0, 1)) v = -v;
        return v[VALUE_BITS-1:0];
    endfunction

    // Receiver stall pattern
    always @(negedge aclk) begin
        case (rx_mode)
            RX_STEADY: begin
                m_tready <= 1'b1;
            end
            RX_BURSTY: begin
                if (rx_stretch == 0) begin
                    rx_level   = ~rx_level;
                    rx_stretch = $urandom_range(1, 14);
                end
                rx_stretch--;
                m_tready <= rx_level;
            end
            default: begin
                m_tready <= ($urandom_range(0, 4) == 0);
            end
        endcase
    end

    // Check each accepted character against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_text.size() == 0) begin
                $display("%0t: unexpected character %h last %b", $time, m_tdata, m_tlast);
                error_count++;
            end else begin
                oldest_char = pending_text.pop_front();
                if (m_tdata !== oldest_char.character) begin
                    $display("%0t: character expected %h got %h", $time,
                             oldest_char.character, m_tdata);
                    error_count++;
                end
                if (m_tlast !== oldest_char.last_char) begin
                    $display("%0t: last_char expected %b got %b", $time,
                             oldest_char.last_char, m_tlast);
                    error_count++;
                end
            end
        end
    end

    // Extremes, zero, most negative value, digit carries
    task automatic test_directed_values();
        logic [VALUE_BITS-1:0] values[$];
        rx_mode    = RX_BURSTY;
        tx_gaps_on = 1'b1;
        values = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
                   -32'sd1000000000, 32'd999999999, -32'sd999999999, 32'h5555_5555,
                   32'hAAAA_AAAA, 32'd12345, -32'sd9, 32'hFFFF_FFFE, 32'd2000000000,
                   32'h0000_FFFF, 32'hFFFF_0000};
        foreach (values[i]) send_value(values[i]);
    endtask

    // Every text length, both signs
    task automatic test_digit_lengths();
        longint unsigned p;
        rx_mode = RX_SPARSE;
        p = 1;
        for (int n = 1; n <= 10; n++) begin
            send_value(VALUE_BITS'(p * 10 - 1 > 64'd2147483647 ? 64'd2147483647 : p * 10 - 1));
            send_value(-VALUE_BITS'(p));
            p = p * 10;
        end
    endtask

    // Random words under random idling on both sides
    task automatic test_random_values();
        rx_mode    = RX_BURSTY;
        tx_gaps_on = 1'b1;
        for (int i = 0; i < 100; i++) begin
            if (i == 50) rx_mode = RX_SPARSE;
            if ($urandom_range(0, 2) == 0) send_value($urandom());
            else send_value(random_sized_value());
        end
    endtask

    // Full rate: no sender gaps, receiver always ready
    task automatic test_back_to_back();
        rx_mode    = RX_STEADY;
        tx_gaps_on = 1'b0;
        for (int i = 0; i < 30; i++) send_value($urandom());
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        test_directed_values();
        test_digit_lengths();
        test_random_values();
        test_back_to_back();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        // Drain, then keep watching for stray output
        while (pending_text.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
